/* src/pebs_pkg.sv */
// ----------------------------------------------------------------------------
// pebs_pkg
// Shared types and constants for the peak element binary search block.
// ----------------------------------------------------------------------------
package pebs_pkg;

  localparam int DATA_W = 32;
  localparam int PEAK_W = 10;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_CMP,
    ST_EMIT
  } pebs_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // input transfer this cycle
    logic start;  // transfer carries last: set up search bounds
    logic rd;     // read element mid and mid+1
    logic cmp;    // compare read pair, narrow bounds
    logic emit;   // load result register
  } pebs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic lo_lt_hi;  // search still open
    logic out_busy;  // result register full and stalled
  } pebs_sts_t;

endpackage

/* src/pebs_ctrl.sv */
// ----------------------------------------------------------------------------
// pebs_ctrl
// Sequencer: load phase, then read/compare steps, then emit.
// ----------------------------------------------------------------------------
module pebs_ctrl import pebs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      last,
  input  pebs_sts_t sts,
  output logic      in_stall,
  output pebs_cmd_t cmd
);

  pebs_state_t state;
  pebs_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    cmd        = '0;
    case (state)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (last) begin
            cmd.start  = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (sts.lo_lt_hi) begin
          cmd.rd     = 1'b1;
          state_next = ST_CMP;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = ST_READ;
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

/* src/pebs_dp.sv */
// ----------------------------------------------------------------------------
// pebs_dp
// Element store, fill count, search bounds, compare and result register.
// ----------------------------------------------------------------------------
module pebs_dp import pebs_pkg::*; #(
  parameter int MAX_LEN = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  pebs_cmd_t                cmd,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     out_stall,
  output pebs_sts_t                sts,
  output logic                     out_valid,
  output logic [PEAK_W-1:0]        peak_index,
  output logic                     overflow
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  logic [DATA_W-1:0] mem [MAX_LEN];
  logic [CW-1:0]     count;
  logic              dropped;
  logic              ovf_hold;
  logic [AW-1:0]     lo;
  logic [AW-1:0]     hi;
  logic [AW-1:0]     mid;
  logic [DATA_W-1:0] rd_a;
  logic [DATA_W-1:0] rd_b;

  logic              full;
  logic [AW:0]       sum;
  logic [AW-1:0]     mid_comb;
  logic [AW-1:0]     mid_p1;
  logic [AW-1:0]     mid_reg_p1;
  logic [AW-1:0]     hi_start;
  logic [AW+PEAK_W-1:0] lo_ext;

  assign full       = (count == CW'(MAX_LEN));
  assign sum        = {1'b0, lo} + {1'b0, hi};
  assign mid_comb   = sum[AW:1];
  assign mid_p1     = mid_comb + AW'(1);
  assign mid_reg_p1 = mid + AW'(1);
  // bound before this element is counted is the new count minus one
  assign hi_start   = full ? AW'(MAX_LEN - 1) : count[AW-1:0];
  assign lo_ext     = {{PEAK_W{1'b0}}, lo};

  assign sts.lo_lt_hi = (lo < hi);
  assign sts.out_busy = out_valid & out_stall;

  // store write
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[count[AW-1:0]] <= value;
    end
  end

  // two registered reads
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_a <= mem[mid_comb];
      rd_b <= mem[mid_p1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      dropped  <= 1'b0;
      ovf_hold <= 1'b0;
      lo       <= '0;
      hi       <= '0;
    end else begin
      if (cmd.load) begin
        if (cmd.start) begin
          count    <= '0;
          dropped  <= 1'b0;
          ovf_hold <= dropped | full;
          lo       <= '0;
          hi       <= hi_start;
        end else if (full) begin
          dropped <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.cmp) begin
        if ($signed(rd_a) < $signed(rd_b)) begin
          lo <= mid_reg_p1;
        end else begin
          hi <= mid;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      mid <= mid_comb;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      peak_index <= lo_ext[PEAK_W-1:0];
      overflow   <= ovf_hold;
    end
  end

endmodule

/* src/peak_element_binary_search.sv */
// ----------------------------------------------------------------------------
// peak_element_binary_search
// Stores a signed array, then binary searches it for a peak element.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, value, last): one 32-bit signed element
//   per transfer, in array order, last high on the final element. While
//   loading, one transfer is taken every cycle. Elements past MAX_LEN are
//   dropped and the result's overflow bit is set.
//   Output channel (out_valid/out_stall, peak_index, overflow): one result
//   per array, held in a result register until transferred.
//   Search: after the last element, each halving step reads mid and mid+1
//   from the store, then compares them; there are at most
//   ceil(log2(count)) steps. The sequencer then sees the bounds meet and,
//   once the result register is free, loads it and raises out_valid.
//   The store's dual read port and the compare set the step time.
//   During the search in_stall is high. Once the result is loaded the next
//   array may start loading even if the result is still stalled; a second
//   finished search waits for the result register to empty.
//   Reset (rst, synchronous) empties the array and result register; the
//   store itself is not cleared, since only written entries are read.
// ----------------------------------------------------------------------------
module peak_element_binary_search import pebs_pkg::*; #(
  parameter int MAX_LEN = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PEAK_W-1:0]        peak_index,
  output logic                     overflow
);

  pebs_cmd_t cmd;
  pebs_sts_t sts;

  // sequencer: load, read/compare loop, emit
  pebs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // store, bounds and result register
  pebs_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .value      (value),
    .out_stall  (out_stall),
    .sts        (sts),
    .out_valid  (out_valid),
    .peak_index (peak_index),
    .overflow   (overflow)
  );

endmodule
